// File: rtl/bmp_stream_pixel_decoder_macros.svh
// Assertion macros shared by the BMP stream pixel decoder modules.
`ifndef BMP_STREAM_PIXEL_DECODER_MACROS_SVH
`define BMP_STREAM_PIXEL_DECODER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BMP_ASSERT_IMP(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("bmp decoder assertion failed");

// The condition must hold in the cycle after the trigger.
`define BMP_ASSERT_NXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("bmp decoder assertion failed");

`endif

// File: rtl/bmp_dec_pkg.sv
// Package with the constants, codes and types of the BMP stream pixel decoder.
package bmp_dec_pkg;

   localparam int unsigned MAX_DIM  = 4096;
   localparam int unsigned DIM_W    = $clog2(MAX_DIM + 1);
   localparam int unsigned STRIDE_W = $clog2(MAX_DIM * 4 + 1);
   localparam int unsigned COORD_W  = 12;
   localparam int unsigned PIXEL_W  = 32;
   localparam int unsigned STATUS_W = 2;

   localparam logic [7:0]  SIG_B       = 8'h42;
   localparam logic [7:0]  SIG_M       = 8'h4d;
   localparam logic [31:0] HEADER_LEN  = 32'd54;
   localparam logic [31:0] SIG_B_IDX   = 32'd0;
   localparam logic [31:0] SIG_M_IDX   = 32'd1;
   localparam logic [31:0] OFFSET_LO   = 32'd10;
   localparam logic [31:0] WIDTH_LO    = 32'd18;
   localparam logic [31:0] HEIGHT_LO   = 32'd22;
   localparam logic [31:0] DEPTH_LO    = 32'd28;
   localparam logic [31:0] HEADER_LAST = 32'd53;

   localparam logic [15:0] DEPTH_8  = 16'd8;
   localparam logic [15:0] DEPTH_16 = 16'd16;
   localparam logic [15:0] DEPTH_24 = 16'd24;
   localparam logic [15:0] DEPTH_32 = 16'd32;

   localparam logic [STATUS_W-1:0] ST_PIXEL     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIG   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_DEPTH = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_GEOM  = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic                last;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// File: rtl/bmp_dec_out_buf.sv
// Two-entry result buffer: an output register with a skid register behind it.
`include "bmp_stream_pixel_decoder_macros.svh"

module bmp_dec_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  bmp_dec_pkg::result_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output bmp_dec_pkg::result_type out_data
);

   logic                    main_valid_ff, main_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   bmp_dec_pkg::result_type main_ff, main_in;
   bmp_dec_pkg::result_type skid_ff, skid_in;
   logic                    push, pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `BMP_ASSERT_IMP(a_skid_needs_main, skid_valid_ff, main_valid_ff)
   `BMP_ASSERT_NXT(a_main_holds, main_valid_ff && !out_ready, main_valid_ff && $stable(main_ff))
   `BMP_ASSERT_NXT(a_fill_skid, push && main_valid_ff && !out_ready, skid_valid_ff)

endmodule

// File: rtl/bmp_stream_pixel_decoder.sv
// Top level of the BMP stream pixel decoder: header parser, pixel assembly and conversion.
//
// The req channel carries a BMP file one byte per transaction; req_first_byte marks byte 0
// of a new file and restarts the parser. Bytes without any start mark after reset are
// parsed as the start of a file. The rsp channel returns at most one result per byte:
// a converted pixel with its column, its row counted from the top and a last flag, or a
// single error status (bad signature, unsupported depth, bad geometry). After an error
// or the last pixel, bytes are swallowed until the next start mark.
// The csr channel writes the output format (0 RGB565 in the low 16 bits, 1 ARGB8888);
// it is always ready and is sampled as each pixel is produced.
// A result is valid on rsp the cycle after the byte completing it is accepted, unless an
// earlier result is held by a stalled receiver. One byte is taken per cycle while
// req_ready is high. The results pass through a two-entry buffer, so req_ready falls only
// once two results wait on a stalled receiver, and rises the cycle after one is taken.
// Reset clears the parser to the header phase, empties the buffer and selects ARGB8888.
`include "bmp_stream_pixel_decoder_macros.svh"

module bmp_stream_pixel_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel,
   output logic [11:0] rsp_col,
   output logic [11:0] rsp_row,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_out_format
);

   localparam int unsigned DIM_W    = bmp_dec_pkg::DIM_W;
   localparam int unsigned STRIDE_W = bmp_dec_pkg::STRIDE_W;

   logic                     out_format_ff;
   bmp_dec_pkg::phase_type   phase_ff, phase_in, cur_phase;
   logic [31:0]              byte_index_ff, byte_index_in, cur_byte_index;
   logic [31:0]              data_offset_ff, data_offset_in, cur_data_offset;
   logic [31:0]              raw_width_ff, raw_width_in, cur_raw_width;
   logic [31:0]              raw_height_ff, raw_height_in, cur_raw_height;
   logic [15:0]              bit_depth_ff, bit_depth_in, cur_bit_depth;
   logic [STRIDE_W-1:0]      row_stride_ff, row_stride_in, cur_row_stride;
   logic [STRIDE_W-1:0]      data_bytes_ff, data_bytes_in, cur_data_bytes;
   logic [DIM_W-1:0]         col_count_ff, col_count_in, cur_col_count;
   logic [DIM_W-1:0]         file_row_ff, file_row_in, cur_file_row;
   logic [STRIDE_W-1:0]      row_byte_pos_ff, row_byte_pos_in, cur_row_byte_pos;
   logic [1:0]               pixel_byte_pos_ff, pixel_byte_pos_in, cur_pixel_byte_pos;
   logic [23:0]              pixel_gather_ff, pixel_gather_in, cur_pixel_gather;

   logic                     req_take;
   logic                     res_valid;
   logic                     buf_ready;
   bmp_dec_pkg::result_type  res, buf_out;
   logic [1:0]               lane;
   logic                     do_pix;
   logic [2:0]               bpp_bytes;
   logic                     is_last;
   logic [STRIDE_W-1:0]      rbp_next;
   logic [DIM_W-1:0]         frow_next;
   logic [STRIDE_W-1:0]      hdr_data_bytes;
   logic                     depth_ok;

   function automatic logic [31:0] convert(input logic [23:0] gather, input logic [7:0] t,
                                           input logic [15:0] depth, input logic fmt);
      logic [7:0]  b0, b1, b2, r, g, b, a;
      logic [15:0] v;
      logic        direct;
      logic [31:0] direct_val;
      b0 = gather[7:0];
      b1 = gather[15:8];
      b2 = gather[23:16];
      a = 8'hff;
      v = {t, b0};
      direct = 1'b0;
      direct_val = '0;
      r = t;
      g = b1;
      b = b0;
      case (depth)
         bmp_dec_pkg::DEPTH_8: begin
            direct_val = (32'(t) >> 3) | ((32'(t) & 32'hfc) << 3) | ((32'(t) & 32'hf8) << 8);
            direct = !fmt;
            r = t & 8'hf8;
            g = t & 8'hfc;
            b = t & 8'hf8;
         end
         bmp_dec_pkg::DEPTH_16: begin
            direct_val = 32'(v);
            direct = !fmt;
            r = {v[15:11], 3'b000};
            g = {v[10:5], 2'b00};
            b = {v[4:0], 3'b000};
         end
         bmp_dec_pkg::DEPTH_24: begin
            r = t;
            g = b1;
            b = b0;
         end
         default: begin
            r = b2;
            g = b1;
            b = b0;
            a = t;
         end
      endcase
      if (direct) begin
         return direct_val;
      end else if (!fmt) begin
         return {16'h0000, r[7:3], g[7:2], b[7:3]};
      end
      return {a, r, g, b};
   endfunction

   assign req_ready = buf_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // A start mark makes the byte see the parser as freshly reset.
   always_comb begin
      if (req_first_byte) begin
         cur_phase          = bmp_dec_pkg::PH_HEADER;
         cur_byte_index     = '0;
         cur_data_offset    = '0;
         cur_raw_width      = '0;
         cur_raw_height     = '0;
         cur_bit_depth      = '0;
         cur_row_stride     = '0;
         cur_data_bytes     = '0;
         cur_col_count      = '0;
         cur_file_row       = '0;
         cur_row_byte_pos   = '0;
         cur_pixel_byte_pos = '0;
         cur_pixel_gather   = '0;
      end else begin
         cur_phase          = phase_ff;
         cur_byte_index     = byte_index_ff;
         cur_data_offset    = data_offset_ff;
         cur_raw_width      = raw_width_ff;
         cur_raw_height     = raw_height_ff;
         cur_bit_depth      = bit_depth_ff;
         cur_row_stride     = row_stride_ff;
         cur_data_bytes     = data_bytes_ff;
         cur_col_count      = col_count_ff;
         cur_file_row       = file_row_ff;
         cur_row_byte_pos   = row_byte_pos_ff;
         cur_pixel_byte_pos = pixel_byte_pos_ff;
         cur_pixel_gather   = pixel_gather_ff;
      end
   end

   always_comb begin
      phase_in          = cur_phase;
      byte_index_in     = cur_byte_index;
      data_offset_in    = cur_data_offset;
      raw_width_in      = cur_raw_width;
      raw_height_in     = cur_raw_height;
      bit_depth_in      = cur_bit_depth;
      row_stride_in     = cur_row_stride;
      data_bytes_in     = cur_data_bytes;
      col_count_in      = cur_col_count;
      file_row_in       = cur_file_row;
      row_byte_pos_in   = cur_row_byte_pos;
      pixel_byte_pos_in = cur_pixel_byte_pos;
      pixel_gather_in   = cur_pixel_gather;
      res_valid         = 1'b0;
      res               = '0;
      lane              = '0;
      do_pix            = 1'b0;
      is_last           = 1'b0;
      rbp_next          = cur_row_byte_pos + STRIDE_W'(1);
      frow_next         = cur_file_row + DIM_W'(1);
      bpp_bytes         = cur_bit_depth[5:3];
      hdr_data_bytes    = STRIDE_W'(cur_raw_width[DIM_W-1:0]) * STRIDE_W'(bpp_bytes);
      depth_ok          = (cur_bit_depth == bmp_dec_pkg::DEPTH_8)  ||
                          (cur_bit_depth == bmp_dec_pkg::DEPTH_16) ||
                          (cur_bit_depth == bmp_dec_pkg::DEPTH_24) ||
                          (cur_bit_depth == bmp_dec_pkg::DEPTH_32);

      case (cur_phase)
         bmp_dec_pkg::PH_HEADER: begin
            byte_index_in = cur_byte_index + 32'd1;
            if ((cur_byte_index == bmp_dec_pkg::SIG_B_IDX && req_in_byte != bmp_dec_pkg::SIG_B) ||
                (cur_byte_index == bmp_dec_pkg::SIG_M_IDX && req_in_byte != bmp_dec_pkg::SIG_M)) begin
               res_valid  = 1'b1;
               res.status = bmp_dec_pkg::ST_BAD_SIG;
               phase_in   = bmp_dec_pkg::PH_DONE;
            end else begin
               if (cur_byte_index >= bmp_dec_pkg::OFFSET_LO &&
                   cur_byte_index < bmp_dec_pkg::OFFSET_LO + 32'd4) begin
                  lane = 2'(cur_byte_index - bmp_dec_pkg::OFFSET_LO);
                  data_offset_in[{lane, 3'b000} +: 8] =
                     cur_data_offset[{lane, 3'b000} +: 8] | req_in_byte;
               end
               if (cur_byte_index >= bmp_dec_pkg::WIDTH_LO &&
                   cur_byte_index < bmp_dec_pkg::WIDTH_LO + 32'd4) begin
                  lane = 2'(cur_byte_index - bmp_dec_pkg::WIDTH_LO);
                  raw_width_in[{lane, 3'b000} +: 8] =
                     cur_raw_width[{lane, 3'b000} +: 8] | req_in_byte;
               end
               if (cur_byte_index >= bmp_dec_pkg::HEIGHT_LO &&
                   cur_byte_index < bmp_dec_pkg::HEIGHT_LO + 32'd4) begin
                  lane = 2'(cur_byte_index - bmp_dec_pkg::HEIGHT_LO);
                  raw_height_in[{lane, 3'b000} +: 8] =
                     cur_raw_height[{lane, 3'b000} +: 8] | req_in_byte;
               end
               if (cur_byte_index >= bmp_dec_pkg::DEPTH_LO &&
                   cur_byte_index < bmp_dec_pkg::DEPTH_LO + 32'd2) begin
                  lane = 2'(cur_byte_index - bmp_dec_pkg::DEPTH_LO);
                  bit_depth_in[{lane[0], 3'b000} +: 8] =
                     cur_bit_depth[{lane[0], 3'b000} +: 8] | req_in_byte;
               end
               // The depth check takes precedence over the geometry check.
               if (cur_byte_index == bmp_dec_pkg::HEADER_LAST) begin
                  if (!depth_ok) begin
                     res_valid  = 1'b1;
                     res.status = bmp_dec_pkg::ST_BAD_DEPTH;
                     phase_in   = bmp_dec_pkg::PH_DONE;
                  end else if (cur_raw_width == 32'd0 ||
                               cur_raw_width > 32'(bmp_dec_pkg::MAX_DIM) ||
                               cur_raw_height == 32'd0 || cur_raw_height[31] ||
                               cur_raw_height > 32'(bmp_dec_pkg::MAX_DIM) ||
                               cur_data_offset < bmp_dec_pkg::HEADER_LEN) begin
                     res_valid  = 1'b1;
                     res.status = bmp_dec_pkg::ST_BAD_GEOM;
                     phase_in   = bmp_dec_pkg::PH_DONE;
                  end else begin
                     // Each row is padded up to a multiple of four bytes.
                     data_bytes_in = hdr_data_bytes;
                     row_stride_in = (hdr_data_bytes + STRIDE_W'(3)) & ~STRIDE_W'(3);
                     phase_in = (cur_data_offset == bmp_dec_pkg::HEADER_LEN) ?
                                bmp_dec_pkg::PH_PIXELS : bmp_dec_pkg::PH_SKIP;
                  end
               end
            end
         end
         bmp_dec_pkg::PH_SKIP: begin
            if (cur_byte_index < cur_data_offset) begin
               byte_index_in = cur_byte_index + 32'd1;
               if (cur_byte_index + 32'd1 >= cur_data_offset) begin
                  phase_in = bmp_dec_pkg::PH_PIXELS;
               end
            end else begin
               phase_in = bmp_dec_pkg::PH_PIXELS;
               do_pix   = 1'b1;
            end
         end
         bmp_dec_pkg::PH_PIXELS: begin
            do_pix = 1'b1;
         end
         default: begin
         end
      endcase

      if (do_pix) begin
         if (cur_row_byte_pos < cur_data_bytes) begin
            if ({1'b0, cur_pixel_byte_pos} + 3'd1 < bpp_bytes) begin
               if (cur_pixel_byte_pos != 2'd3) begin
                  pixel_gather_in[{cur_pixel_byte_pos, 3'b000} +: 8] =
                     cur_pixel_gather[{cur_pixel_byte_pos, 3'b000} +: 8] | req_in_byte;
               end
               pixel_byte_pos_in = cur_pixel_byte_pos + 2'd1;
            end else begin
               is_last = (32'(cur_file_row) + 32'd1 == cur_raw_height) &&
                         (32'(cur_col_count) + 32'd1 == cur_raw_width);
               res_valid  = 1'b1;
               res.pixel  = convert(cur_pixel_gather, req_in_byte, cur_bit_depth, out_format_ff);
               res.col    = bmp_dec_pkg::COORD_W'(cur_col_count);
               res.row    = bmp_dec_pkg::COORD_W'(cur_raw_height - 32'd1 - 32'(cur_file_row));
               res.last   = is_last;
               res.status = bmp_dec_pkg::ST_PIXEL;
               pixel_byte_pos_in = '0;
               pixel_gather_in   = '0;
               col_count_in      = cur_col_count + DIM_W'(1);
               if (is_last) begin
                  phase_in = bmp_dec_pkg::PH_DONE;
               end
            end
         end
         // Once the last pixel is out nothing else moves.
         if (!is_last) begin
            row_byte_pos_in = rbp_next;
            if (rbp_next >= cur_row_stride) begin
               row_byte_pos_in   = '0;
               col_count_in      = '0;
               pixel_byte_pos_in = '0;
               pixel_gather_in   = '0;
               file_row_in       = frow_next;
               if (32'(frow_next) >= cur_raw_height) begin
                  phase_in = bmp_dec_pkg::PH_DONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_format_ff     <= 1'b1;
         phase_ff          <= bmp_dec_pkg::PH_HEADER;
         byte_index_ff     <= '0;
         data_offset_ff    <= '0;
         raw_width_ff      <= '0;
         raw_height_ff     <= '0;
         bit_depth_ff      <= '0;
         row_stride_ff     <= '0;
         data_bytes_ff     <= '0;
         col_count_ff      <= '0;
         file_row_ff       <= '0;
         row_byte_pos_ff   <= '0;
         pixel_byte_pos_ff <= '0;
         pixel_gather_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            out_format_ff <= csr_out_format;
         end
         if (req_take) begin
            phase_ff          <= phase_in;
            byte_index_ff     <= byte_index_in;
            data_offset_ff    <= data_offset_in;
            raw_width_ff      <= raw_width_in;
            raw_height_ff     <= raw_height_in;
            bit_depth_ff      <= bit_depth_in;
            row_stride_ff     <= row_stride_in;
            data_bytes_ff     <= data_bytes_in;
            col_count_ff      <= col_count_in;
            file_row_ff       <= file_row_in;
            row_byte_pos_ff   <= row_byte_pos_in;
            pixel_byte_pos_ff <= pixel_byte_pos_in;
            pixel_gather_ff   <= pixel_gather_in;
         end
      end
   end

   bmp_dec_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take && res_valid),
      .in_ready  (buf_ready),
      .in_data   (res),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (buf_out)
   );

   assign rsp_pixel  = buf_out.pixel;
   assign rsp_col    = buf_out.col;
   assign rsp_row    = buf_out.row;
   assign rsp_last   = buf_out.last;
   assign rsp_status = buf_out.status;

   `BMP_ASSERT_IMP(a_pix_depth, phase_ff == bmp_dec_pkg::PH_PIXELS, bit_depth_ff == bmp_dec_pkg::DEPTH_8 || bit_depth_ff == bmp_dec_pkg::DEPTH_16 || bit_depth_ff == bmp_dec_pkg::DEPTH_24 || bit_depth_ff == bmp_dec_pkg::DEPTH_32)
   `BMP_ASSERT_IMP(a_row_pos, phase_ff == bmp_dec_pkg::PH_PIXELS, row_byte_pos_ff < row_stride_ff)
   `BMP_ASSERT_IMP(a_done_quiet, req_take && !req_first_byte && phase_ff == bmp_dec_pkg::PH_DONE, !res_valid)

endmodule

// File: tb/tb_bmp_stream_pixel_decoder.sv
// Self-checking testbench for the BMP stream pixel decoder with a built-in pixel predictor.
module tb_bmp_stream_pixel_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic FMT_RGB565       = 1'b0;
   localparam logic FMT_ARGB8888     = 1'b1;
   localparam int   WATCHDOG_LIMIT   = 3000;
   localparam int   LONG_HOLD_CYCLES = 400;
   localparam int   SETTLE_CYCLES    = 4;
   localparam int   DRAIN_CYCLES     = 16;
   localparam int   RANDOM_BYTES     = 150;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } stream_item_type;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte    = 8'd0;
   logic        req_first_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_pixel;
   logic [11:0] rsp_col;
   logic [11:0] rsp_row;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic        csr_out_format = 1'b0;

   bmp_stream_pixel_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_first_byte (req_first_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel      (rsp_pixel),
      .rsp_col        (rsp_col),
      .rsp_row        (rsp_row),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_out_format (csr_out_format)
   );

   always #5 clock = ~clock;

   stream_item_type          byte_backlog_q[$];
   stream_item_type          image_q[$];
   bmp_dec_pkg::result_type  decoded_q[$];
   int                       error_count  = 0;
   int                       queued_total = 0;
   bit                       hold_wanted  = 1'b0;

   // Predictor state, mirroring the parser of the block.
   logic                   out_fmt;
   bmp_dec_pkg::phase_type ph;
   logic [31:0]            hdr_idx;
   logic [31:0]            pix_offset;
   logic [31:0]            img_width;
   logic [31:0]            img_height;
   logic [15:0]            img_depth;
   logic [31:0]            stride;
   logic [31:0]            col_n;
   logic [31:0]            row_n;
   logic [31:0]            row_pos;
   logic [31:0]            gather_pos;
   logic [23:0]            gather;

   function automatic void restart_parser();
      ph = bmp_dec_pkg::PH_HEADER;
      hdr_idx = 0; pix_offset = 0; img_width = 0; img_height = 0; img_depth = 0;
      stride = 0; col_n = 0; row_n = 0; row_pos = 0; gather_pos = 0; gather = 0;
   endfunction

   function automatic logic [31:0] to_out_pixel(input logic [7:0] t);
      logic [31:0] t32, word, r, g, b, a;
      t32 = {24'd0, t};
      a = 32'hff;
      if (img_depth == bmp_dec_pkg::DEPTH_8) begin
         if (out_fmt == FMT_RGB565)
            return (t32 >> 3) | ((t32 & 32'hfc) << 3) | ((t32 & 32'hf8) << 8);
         r = t32 & 32'hf8;
         g = t32 & 32'hfc;
         b = r;
      end else if (img_depth == bmp_dec_pkg::DEPTH_16) begin
         word = {16'd0, t, gather[7:0]};
         if (out_fmt == FMT_RGB565)
            return word;
         r = ((word >> 11) & 32'h1f) << 3;
         g = ((word >> 5) & 32'h3f) << 2;
         b = (word & 32'h1f) << 3;
      end else if (img_depth == bmp_dec_pkg::DEPTH_24) begin
         b = 32'(gather[7:0]);
         g = 32'(gather[15:8]);
         r = t32;
      end else begin
         b = 32'(gather[7:0]);
         g = 32'(gather[15:8]);
         r = 32'(gather[23:16]);
         a = t32;
      end
      if (out_fmt == FMT_RGB565)
         return ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
      return (a << 24) | (r << 16) | (g << 8) | b;
   endfunction

   // Advances the predicted parser by one file byte; returns 1 when a result is due.
   function automatic bit decode_byte(input logic [7:0] v, input logic start,
                                      output bmp_dec_pkg::result_type res);
      logic [31:0] i, bpp, data_bytes, flipped;
      bit          is_last, got;
      res = '0;
      got = 1'b0;
      if (start)
         restart_parser();
      if (ph == bmp_dec_pkg::PH_DONE)
         return 1'b0;

      if (ph == bmp_dec_pkg::PH_HEADER) begin
         i = hdr_idx;
         hdr_idx++;
         if ((i == bmp_dec_pkg::SIG_B_IDX && v != bmp_dec_pkg::SIG_B) ||
             (i == bmp_dec_pkg::SIG_M_IDX && v != bmp_dec_pkg::SIG_M)) begin
            res.status = bmp_dec_pkg::ST_BAD_SIG;
            ph = bmp_dec_pkg::PH_DONE;
            return 1'b1;
         end
         if (i >= bmp_dec_pkg::OFFSET_LO && i < bmp_dec_pkg::OFFSET_LO + 32'd4)
            pix_offset |= {24'd0, v} << (8 * (i - bmp_dec_pkg::OFFSET_LO));
         if (i >= bmp_dec_pkg::WIDTH_LO && i < bmp_dec_pkg::WIDTH_LO + 32'd4)
            img_width |= {24'd0, v} << (8 * (i - bmp_dec_pkg::WIDTH_LO));
         if (i >= bmp_dec_pkg::HEIGHT_LO && i < bmp_dec_pkg::HEIGHT_LO + 32'd4)
            img_height |= {24'd0, v} << (8 * (i - bmp_dec_pkg::HEIGHT_LO));
         if (i >= bmp_dec_pkg::DEPTH_LO && i < bmp_dec_pkg::DEPTH_LO + 32'd2)
            img_depth |= {8'd0, v} << (8 * (i - bmp_dec_pkg::DEPTH_LO));
         if (i == bmp_dec_pkg::HEADER_LAST) begin
            // The depth check takes priority over the geometry check.
            if (img_depth != bmp_dec_pkg::DEPTH_8 && img_depth != bmp_dec_pkg::DEPTH_16 &&
                img_depth != bmp_dec_pkg::DEPTH_24 && img_depth != bmp_dec_pkg::DEPTH_32) begin
               res.status = bmp_dec_pkg::ST_BAD_DEPTH;
               ph = bmp_dec_pkg::PH_DONE;
               return 1'b1;
            end
            if (img_width == 0 || img_width > bmp_dec_pkg::MAX_DIM || img_height == 0 ||
                img_height[31] || img_height > bmp_dec_pkg::MAX_DIM ||
                pix_offset < bmp_dec_pkg::HEADER_LEN) begin
               res.status = bmp_dec_pkg::ST_BAD_GEOM;
               ph = bmp_dec_pkg::PH_DONE;
               return 1'b1;
            end
            stride = ({16'd0, img_depth} * img_width + 32'd31) / 32'd32 * 32'd4;
            ph = (pix_offset == bmp_dec_pkg::HEADER_LEN) ? bmp_dec_pkg::PH_PIXELS
                                                          : bmp_dec_pkg::PH_SKIP;
         end
         return 1'b0;
      end

      if (ph == bmp_dec_pkg::PH_SKIP) begin
         if (hdr_idx < pix_offset) begin
            hdr_idx++;
            if (hdr_idx >= pix_offset)
               ph = bmp_dec_pkg::PH_PIXELS;
            return 1'b0;
         end
         ph = bmp_dec_pkg::PH_PIXELS;
      end

      bpp = {16'd0, img_depth} / 32'd8;
      data_bytes = img_width * bpp;
      if (row_pos < data_bytes) begin
         if (gather_pos + 32'd1 < bpp) begin
            gather = gather | ({16'd0, v} << (8 * gather_pos[1:0]));
            gather_pos++;
         end else begin
            is_last = (row_n + 32'd1 == img_height) && (col_n + 32'd1 == img_width);
            flipped = img_height - 32'd1 - row_n;
            res.pixel  = to_out_pixel(v);
            res.col    = col_n[11:0];
            res.row    = flipped[11:0];
            res.last   = is_last;
            res.status = bmp_dec_pkg::ST_PIXEL;
            got = 1'b1;
            gather_pos = 0;
            gather = 0;
            col_n++;
            if (is_last) begin
               ph = bmp_dec_pkg::PH_DONE;
               return 1'b1;
            end
         end
      end
      row_pos++;
      if (row_pos >= stride) begin
         // End of a stored row: padding has been consumed.
         row_pos = 0;
         col_n = 0;
         gather_pos = 0;
         gather = 0;
         row_n++;
         if (row_n >= img_height)
            ph = bmp_dec_pkg::PH_DONE;
      end
      return got;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      bmp_dec_pkg::result_type res;
      stream_item_type         it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (decode_byte(req_in_byte, req_first_byte, res))
               decoded_q.push_back(res);
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_backlog_q.size() != 0) begin
               it = byte_backlog_q.pop_front();
               req_valid      <= 1'b1;
               req_in_byte    <= it.data;
               req_first_byte <= it.start;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switches between stall patterns, with one long hold-off on request.
   rx_mode_type rx_mode    = RX_OPEN;
   int          rx_cycle   = 0;
   int          hold_left  = 0;
   bit          hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 97 == 0)
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= ((rx_cycle % 8) < 5);
            endcase
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      bmp_dec_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $error("unexpected result: pixel %0h status %0d", rsp_pixel, rsp_status);
            error_count++;
         end else begin
            want = decoded_q.pop_front();
            check_field("pixel", want.pixel, rsp_pixel);
            check_field("col", 32'(want.col), 32'(rsp_col));
            check_field("row", 32'(want.row), 32'(rsp_row));
            check_field("last", 32'(want.last), 32'(rsp_last));
            check_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // Ends the run when no transaction of any kind completes for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic build_file(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] off, input logic [15:0] dep,
                             input bit mark, input bit body);
      logic [7:0]  d;
      logic [31:0] row_bytes, nbytes;
      image_q.delete();
      for (int j = 0; j < bmp_dec_pkg::HEADER_LEN; j++) begin
         d = 8'($urandom);
         if (j == bmp_dec_pkg::SIG_B_IDX)
            d = bmp_dec_pkg::SIG_B;
         else if (j == bmp_dec_pkg::SIG_M_IDX)
            d = bmp_dec_pkg::SIG_M;
         else if (j >= bmp_dec_pkg::OFFSET_LO && j < bmp_dec_pkg::OFFSET_LO + 4)
            d = 8'(off >> (8 * (j - bmp_dec_pkg::OFFSET_LO)));
         else if (j >= bmp_dec_pkg::WIDTH_LO && j < bmp_dec_pkg::WIDTH_LO + 4)
            d = 8'(w >> (8 * (j - bmp_dec_pkg::WIDTH_LO)));
         else if (j >= bmp_dec_pkg::HEIGHT_LO && j < bmp_dec_pkg::HEIGHT_LO + 4)
            d = 8'(h >> (8 * (j - bmp_dec_pkg::HEIGHT_LO)));
         else if (j >= bmp_dec_pkg::DEPTH_LO && j < bmp_dec_pkg::DEPTH_LO + 2)
            d = 8'(dep >> (8 * (j - bmp_dec_pkg::DEPTH_LO)));
         image_q.push_back({d, (j == 0) ? mark : 1'b0});
      end
      if (body) begin
         row_bytes = ({16'd0, dep} * w + 32'd31) / 32'd32 * 32'd4;
         nbytes = (off - bmp_dec_pkg::HEADER_LEN) + h * row_bytes;
         for (int k = 0; k < nbytes; k++)
            image_q.push_back({8'($urandom), 1'b0});
      end
   endtask

   task automatic queue_range(input int lo, input int hi);
      for (int k = lo; k < hi; k++)
         byte_backlog_q.push_back(image_q[k]);
      queued_total += hi - lo;
   endtask

   task automatic queue_junk(input int n, input int start_odds);
      for (int k = 0; k < n; k++)
         byte_backlog_q.push_back({8'($urandom),
                                   start_odds != 0 && $urandom_range(0, start_odds - 1) == 0});
      queued_total += n;
   endtask

   task automatic settle(input int extra);
      do @(negedge clock);
      while (byte_backlog_q.size() != 0 || req_valid || decoded_q.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_format(input logic f);
      settle(SETTLE_CYCLES);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_out_format <= f;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      out_fmt = f;
      @(negedge clock);
   endtask

   // Sends the built image; a split point inside it changes the format part way through.
   task automatic send_image(input int split_at, input logic new_fmt);
      if (split_at > 0 && split_at < image_q.size()) begin
         queue_range(0, split_at);
         set_format(new_fmt);
         queue_range(split_at, image_q.size());
      end else begin
         queue_range(0, image_q.size());
      end
   endtask

   function automatic logic [15:0] pick_depth();
      case ($urandom_range(0, 3))
         0:       return bmp_dec_pkg::DEPTH_8;
         1:       return bmp_dec_pkg::DEPTH_16;
         2:       return bmp_dec_pkg::DEPTH_24;
         default: return bmp_dec_pkg::DEPTH_32;
      endcase
   endfunction

   initial begin
      logic [31:0] w, h, off;
      logic [15:0] dep;
      int          kind, base, files;
      logic [15:0] depths[4];

      depths = '{bmp_dec_pkg::DEPTH_8, bmp_dec_pkg::DEPTH_16,
                 bmp_dec_pkg::DEPTH_24, bmp_dec_pkg::DEPTH_32};
      out_fmt = FMT_ARGB8888;
      restart_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The receiver holds off while the first image streams in, so the block fills up.
      hold_wanted = 1'b1;

      // A file straight after reset without any start mark.
      build_file(2, 2, bmp_dec_pkg::HEADER_LEN, bmp_dec_pkg::DEPTH_24, 1'b0, 1'b1);
      send_image(0, FMT_ARGB8888);

      // Every depth, in mixed formats, with row padding and a skipped gap.
      foreach (depths[k]) begin
         set_format((k == 1 || k == 2) ? FMT_RGB565 : FMT_ARGB8888);
         build_file(3, 2, (k % 2 == 0) ? bmp_dec_pkg::HEADER_LEN : bmp_dec_pkg::HEADER_LEN + 4,
                    depths[k], 1'b1, 1'b1);
         send_image(0, FMT_ARGB8888);
      end

      // Bad signature on either byte, followed by bytes that must be ignored.
      build_file(2, 2, bmp_dec_pkg::HEADER_LEN, bmp_dec_pkg::DEPTH_8, 1'b1, 1'b0);
      image_q[0] = {bmp_dec_pkg::SIG_B ^ 8'h80, 1'b1};
      queue_range(0, 2);
      queue_junk(2, 0);
      build_file(2, 2, bmp_dec_pkg::HEADER_LEN, bmp_dec_pkg::DEPTH_8, 1'b1, 1'b0);
      image_q[1] = {bmp_dec_pkg::SIG_M ^ 8'h01, 1'b0};
      queue_range(0, 3);
      queue_junk(2, 0);

      // Unsupported depth together with bad geometry, then a negative height alone.
      build_file(0, 0, 0, 16'd12, 1'b1, 1'b0);
      send_image(0, FMT_ARGB8888);
      build_file(4, 32'h8000_0001, bmp_dec_pkg::HEADER_LEN, bmp_dec_pkg::DEPTH_16, 1'b1, 1'b0);
      send_image(0, FMT_ARGB8888);

      // A header cut short by a new file, whose format changes while it is under way.
      build_file(3, 3, bmp_dec_pkg::HEADER_LEN, bmp_dec_pkg::DEPTH_24, 1'b1, 1'b1);
      queue_range(0, 20);
      build_file(4, 3, bmp_dec_pkg::HEADER_LEN, bmp_dec_pkg::DEPTH_16, 1'b1, 1'b1);
      send_image(bmp_dec_pkg::HEADER_LEN + 12, FMT_RGB565);

      // Random part: mostly well-formed small images, some errors, restarts and noise.
      base = queued_total;
      files = 0;
      while (queued_total - base < RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 4);
         dep = pick_depth();
         off = bmp_dec_pkg::HEADER_LEN +
               (($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0);
         if (kind < 70) begin
            build_file(w, h, off, dep, 1'b1, 1'b1);
            if (kind < 10)
               send_image($urandom_range(bmp_dec_pkg::HEADER_LEN, image_q.size() - 1),
                          1'($urandom_range(0, 1)));
            else
               send_image(0, FMT_ARGB8888);
            if ($urandom_range(0, 3) == 0)
               queue_junk($urandom_range(1, 6), 0);
         end else if (kind < 80) begin
            case ($urandom_range(0, 2))
               0: begin
                  build_file(w, h, off, dep, 1'b1, 1'b0);
                  if ($urandom_range(0, 1) == 0)
                     image_q[0] = {bmp_dec_pkg::SIG_B ^ 8'(1 << $urandom_range(0, 7)), 1'b1};
                  else
                     image_q[1] = {bmp_dec_pkg::SIG_M ^ 8'(1 << $urandom_range(0, 7)), 1'b0};
               end
               1: begin
                  dep = 16'($urandom);
                  if (dep == bmp_dec_pkg::DEPTH_8 || dep == bmp_dec_pkg::DEPTH_16 ||
                      dep == bmp_dec_pkg::DEPTH_24 || dep == bmp_dec_pkg::DEPTH_32)
                     dep ^= 16'h0001;
                  build_file(w, h, off, dep, 1'b1, 1'b0);
               end
               default: begin
                  case ($urandom_range(0, 5))
                     0: w = 0;
                     1: w = bmp_dec_pkg::MAX_DIM + 1 + $urandom_range(0, 1000);
                     2: h = 0;
                     3: h = {1'b1, 31'($urandom)};
                     4: h = bmp_dec_pkg::MAX_DIM + 1 + $urandom_range(0, 1000);
                     default: off = $urandom_range(0, bmp_dec_pkg::HEADER_LEN - 1);
                  endcase
                  build_file(w, h, off, dep, 1'b1, 1'b0);
               end
            endcase
            send_image(0, FMT_ARGB8888);
            queue_junk($urandom_range(0, 4), 0);
         end else if (kind < 90) begin
            build_file(w, h, off, dep, 1'b1, 1'b1);
            queue_range(0, $urandom_range(1, image_q.size() - 1));
         end else begin
            queue_junk($urandom_range(1, 20), 8);
         end
         files++;
         if (files % 6 == 0)
            set_format(1'($urandom_range(0, 1)));
      end

      settle(DRAIN_CYCLES);
      if (rsp_valid) begin
         $error("result left over: pixel %0h status %0d", rsp_pixel, rsp_status);
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
